/* rtl/mte_pkg.sv */
// mte_pkg: shared types, character codes and morse symbol tables
// for the morse text encoder; no dependencies
package mte_pkg;

  localparam int CharW = 8;
  localparam int SymMax = 6;
  localparam int LenW = 3;

  localparam logic [CharW-1:0] ChDot = 8'h2E;
  localparam logic [CharW-1:0] ChDash = 8'h2D;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChComma = 8'h2C;
  localparam logic [CharW-1:0] ChQuest = 8'h3F;
  localparam logic [CharW-1:0] ChUpA = 8'h41;
  localparam logic [CharW-1:0] ChUpZ = 8'h5A;
  localparam logic [CharW-1:0] ChLowA = 8'h61;
  localparam logic [CharW-1:0] ChLowZ = 8'h7A;
  localparam logic [CharW-1:0] ChZero = 8'h30;
  localparam logic [CharW-1:0] ChNine = 8'h39;
  localparam logic [CharW-1:0] CaseBit = 8'h20;

  // symbols in reading order from bit 5 down, 1 = dash
  typedef struct packed {
    logic [LenW-1:0]   len;
    logic [SymMax-1:0] bits;
  } mte_code_t;

  // one decoded item, ready to be played out
  typedef struct packed {
    logic              pass;
    logic              gap;
    logic [LenW-1:0]   len;
    logic [SymMax-1:0] bits;
    logic [CharW-1:0]  ch;
  } mte_job_t;

  localparam mte_code_t CodeStop = '{len: 3'd6, bits: 6'b010101};
  localparam mte_code_t CodeComma = '{len: 3'd6, bits: 6'b110011};
  localparam mte_code_t CodeQuest = '{len: 3'd6, bits: 6'b001100};

  function automatic mte_code_t letter_code(input logic [4:0] idx);
    mte_code_t c;
    unique case (idx)
      5'd0:  c = '{len: 3'd2, bits: 6'b010000};
      5'd1:  c = '{len: 3'd4, bits: 6'b100000};
      5'd2:  c = '{len: 3'd4, bits: 6'b101000};
      5'd3:  c = '{len: 3'd3, bits: 6'b100000};
      5'd4:  c = '{len: 3'd1, bits: 6'b000000};
      5'd5:  c = '{len: 3'd4, bits: 6'b001000};
      5'd6:  c = '{len: 3'd3, bits: 6'b110000};
      5'd7:  c = '{len: 3'd4, bits: 6'b000000};
      5'd8:  c = '{len: 3'd2, bits: 6'b000000};
      5'd9:  c = '{len: 3'd4, bits: 6'b011100};
      5'd10: c = '{len: 3'd3, bits: 6'b101000};
      5'd11: c = '{len: 3'd4, bits: 6'b010000};
      5'd12: c = '{len: 3'd2, bits: 6'b110000};
      5'd13: c = '{len: 3'd2, bits: 6'b100000};
      5'd14: c = '{len: 3'd3, bits: 6'b111000};
      5'd15: c = '{len: 3'd4, bits: 6'b011000};
      5'd16: c = '{len: 3'd4, bits: 6'b110100};
      5'd17: c = '{len: 3'd3, bits: 6'b010000};
      5'd18: c = '{len: 3'd3, bits: 6'b000000};
      5'd19: c = '{len: 3'd1, bits: 6'b100000};
      5'd20: c = '{len: 3'd3, bits: 6'b001000};
      5'd21: c = '{len: 3'd4, bits: 6'b000100};
      5'd22: c = '{len: 3'd3, bits: 6'b011000};
      5'd23: c = '{len: 3'd4, bits: 6'b100100};
      5'd24: c = '{len: 3'd4, bits: 6'b101100};
      5'd25: c = '{len: 3'd4, bits: 6'b110000};
      default: c = '{len: 3'd0, bits: 6'b000000};
    endcase
    return c;
  endfunction

  function automatic mte_code_t digit_code(input logic [3:0] idx);
    mte_code_t c;
    unique case (idx)
      4'd0: c = '{len: 3'd5, bits: 6'b111110};
      4'd1: c = '{len: 3'd5, bits: 6'b011110};
      4'd2: c = '{len: 3'd5, bits: 6'b001110};
      4'd3: c = '{len: 3'd5, bits: 6'b000110};
      4'd4: c = '{len: 3'd5, bits: 6'b000010};
      4'd5: c = '{len: 3'd5, bits: 6'b000000};
      4'd6: c = '{len: 3'd5, bits: 6'b100000};
      4'd7: c = '{len: 3'd5, bits: 6'b110000};
      4'd8: c = '{len: 3'd5, bits: 6'b111000};
      4'd9: c = '{len: 3'd5, bits: 6'b111100};
      default: c = '{len: 3'd0, bits: 6'b000000};
    endcase
    return c;
  endfunction

endpackage

/* rtl/mte_lookup.sv */
// mte_lookup: folds case and maps one character to its morse
// code, end of message to the stop code; depends on mte_pkg
module mte_lookup (
  input  logic [7:0]        char_code,
  input  logic              end_of_message,
  output mte_pkg::mte_job_t job
);
  import mte_pkg::*;

  logic [CharW-1:0] up;
  logic [CharW-1:0] l_off;
  logic [CharW-1:0] d_off;
  mte_code_t        code;

  assign up = (char_code >= ChLowA && char_code <= ChLowZ) ? (char_code & ~CaseBit)
                                                            : char_code;
  assign l_off = up - ChUpA;
  assign d_off = up - ChZero;

  always_comb begin
    job = '{pass: 1'b0, gap: 1'b1, len: '0, bits: '0, ch: up};
    code = '{len: '0, bits: '0};
    priority if (end_of_message) begin
      job.gap = 1'b0;
      code = CodeStop;
    end else if (up >= ChUpA && up <= ChUpZ) begin
      code = letter_code(l_off[4:0]);
    end else if (up >= ChZero && up <= ChNine) begin
      code = digit_code(d_off[3:0]);
    end else if (up == ChComma) begin
      code = CodeComma;
    end else if (up == ChQuest) begin
      code = CodeQuest;
    end else begin
      job.pass = 1'b1;
      job.gap = 1'b0;
    end
    job.len = code.len;
    job.bits = code.bits;
  end

endmodule

/* rtl/morse_text_encoder.sv */
// morse_text_encoder: top level, job register and symbol sequencer
// depends on mte_pkg and mte_lookup
//
//  channel   ports                                      transfer
//  input     start, busy, in_char_code, in_end_of_message  start && !busy
//  result    out_valid, out_char, out_last_of_run      out_valid, one cycle
//
// one result per cycle; an item gives 1 to 7 results, played out
// by the single symbol sequencer from the job register
// busy drops in the cycle the last symbol of a job leaves, so items follow gaplessly
// first result of an item passes the job register, then the result register
// synchronous active-low reset clears the active flag and result strobe
// the receiver cannot stall; results are never held
module morse_text_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_message,
  output logic       out_valid,
  output logic [7:0] out_char,
  output logic       out_last_of_run
);
  import mte_pkg::*;

  mte_job_t         lk_job;
  mte_job_t         job_r, job_nxt;
  logic             act_r, act_nxt;
  logic             accept;
  logic [CharW-1:0] sym_ch;
  logic             sym_last;
  logic             out_valid_r;
  logic [CharW-1:0] out_char_r;
  logic             out_last_r;

  mte_lookup u_lookup (
    .char_code      (in_char_code),
    .end_of_message (in_end_of_message),
    .job            (lk_job)
  );

  always_comb begin
    job_nxt = job_r;
    priority if (job_r.pass) begin
      sym_ch = job_r.ch;
      sym_last = 1'b1;
    end else if (job_r.len != '0) begin
      sym_ch = job_r.bits[SymMax-1] ? ChDash : ChDot;
      sym_last = (job_r.len == LenW'(1)) && !job_r.gap;
      job_nxt.bits = {job_r.bits[SymMax-2:0], 1'b0};
      job_nxt.len = job_r.len - LenW'(1);
    end else begin
      sym_ch = ChSpace;
      sym_last = 1'b1;
    end
  end

  assign busy = act_r && !sym_last;
  assign accept = start && !busy;
  assign act_nxt = accept || (act_r && !sym_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
      out_valid_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= lk_job;
    end else if (act_r) begin
      job_r <= job_nxt;
    end
    out_char_r <= sym_ch;
    out_last_r <= sym_last;
  end

  assign out_valid = out_valid_r;
  assign out_char = out_char_r;
  assign out_last_of_run = out_last_r;

endmodule

/* rtl/mte_checker.sv */
// mte_checker: port-level assertions for morse_text_encoder, bound to the top
// depends on mte_pkg
module mte_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [7:0] out_char,
  input logic       out_last_of_run
);
  import mte_pkg::*;

  // every transfer starts a run of results
  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("no result after input transfer");

  // a run has no holes
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |=> out_valid)
    else $error("run broken before its last result");

  // no result follows the end of a run without a preceding transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run && !$past(start && !busy)) |=> !out_valid)
    else $error("result without input transfer");

  // only dots and dashes come before the end of a run
  a_mid_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |-> (out_char == ChDot || out_char == ChDash))
    else $error("non-symbol inside a run");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid && !busy))
    else $error("not idle after reset");

endmodule

bind morse_text_encoder mte_checker u_mte_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_char        (out_char),
  .out_last_of_run (out_last_of_run)
);
